/* rtl/coprime_pair_pi_estimator_assert.svh */
// Assertion macros used by the port-level checker of the pi estimator
`ifndef COPRIME_PAIR_PI_ESTIMATOR_ASSERT_SVH
`define COPRIME_PAIR_PI_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define CPPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define CPPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/cppe_pkg.sv */
// Shared types and constants of the coprime-pair pi estimator
package cppe_pkg;

  localparam int unsigned SAMPLE_IN_BITS = 64;
  localparam int unsigned CNT_BITS       = 32;
  localparam int unsigned EST_BITS       = 46;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned CFG_ADDR_BITS  = 3;

  localparam logic [EST_BITS-1:0] EST_MAX           = '1;
  localparam logic [CNT_BITS-1:0] SAMPLE_SIZE_RESET = 32'd1000;

  // register index, taken from paddr above the byte offset
  localparam logic REG_SAMPLE_SIZE = 1'b0;

  typedef struct packed {
    logic done;
    logic coprime;
  } gcd_res_t;

  typedef struct packed {
    logic                done;
    logic [EST_BITS-1:0] estimate;
  } est_res_t;

endpackage

/* rtl/cppe_gcd.sv */
// Iterative binary gcd unit that reports whether a pair is coprime
module cppe_gcd import cppe_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] a_i,
  input  logic [SAMPLE_BITS-1:0] b_i,
  output gcd_res_t               res_o
);

  localparam logic [SAMPLE_BITS-1:0] ONE = SAMPLE_BITS'(1);

  logic [SAMPLE_BITS-1:0] a_q, a_d, b_q, b_d;
  logic                   busy_q, busy_d;
  gcd_res_t               res_q, res_d;
  logic [SAMPLE_BITS:0]   diff_ab, diff_ba;
  logic                   a_zero, b_zero;

  assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
  assign diff_ba = {1'b0, b_q} - {1'b0, a_q};
  assign a_zero  = (a_q == '0);
  assign b_zero  = (b_q == '0);

  always_comb begin
    a_d          = a_q;
    b_d          = b_q;
    busy_d       = busy_q;
    res_d.done   = 1'b0;
    res_d.coprime = res_q.coprime;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (a_zero || b_zero) begin
        // gcd is the other operand; both zero gives gcd 0
        busy_d        = 1'b0;
        res_d.done    = 1'b1;
        res_d.coprime = a_zero ? (b_q == ONE) : (a_q == ONE);
      end else if (!a_q[0] && !b_q[0]) begin
        busy_d        = 1'b0;
        res_d.done    = 1'b1;
        res_d.coprime = 1'b0;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (diff_ab[SAMPLE_BITS]) begin
        b_d = diff_ba[SAMPLE_BITS-1:0] >> 1;
      end else begin
        a_d = diff_ab[SAMPLE_BITS-1:0] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      res_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
    end else begin
      busy_q <= busy_d;
      res_q  <= res_d;
      a_q    <= a_d;
      b_q    <= b_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/cppe_est.sv */
// Estimate unit: restoring divide then digit-by-digit square root on one subtractor
module cppe_est import cppe_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CNT_BITS-1:0] sample_size_i,
  input  logic [CNT_BITS-1:0] count_i,
  output est_res_t            res_o
);

  // 6*size fits 35 bits; dividend is that shifted left by 2*FRACTION_BITS
  localparam int unsigned PROD_BITS = CNT_BITS + 3;
  localparam int unsigned NUM_BITS  = PROD_BITS + 2 * FRACTION_BITS;
  localparam int unsigned QW        = NUM_BITS + 1;
  localparam int unsigned RB        = QW / 2;
  localparam int unsigned UW        = (RB + 2 > CNT_BITS + 1) ? RB + 2 : CNT_BITS + 1;
  localparam int unsigned MW        = (RB > EST_BITS) ? RB : EST_BITS;
  localparam int unsigned CW        = $clog2(QW);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_FIN} state_e;

  state_e              state_q, state_d;
  logic [QW-1:0]       q_q, q_d;
  logic [UW-1:0]       rem_q, rem_d;
  logic [RB-1:0]       root_q, root_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  est_res_t            res_q, res_d;

  logic [UW-1:0]        sub_a, sub_b;
  logic [UW:0]          diff;
  logic                 ge;
  logic [PROD_BITS-1:0] prod;
  logic [MW-1:0]        root_w;

  assign prod   = ({3'b000, sample_size_i} << 2) + ({3'b000, sample_size_i} << 1);
  assign root_w = MW'(root_q);

  // shared subtractor
  always_comb begin
    case (state_q)
      ST_SQRT: begin
        sub_a = {rem_q[UW-3:0], q_q[QW-1:QW-2]};
        sub_b = UW'({root_q, 2'b01});
      end
      default: begin
        sub_a = {rem_q[UW-2:0], q_q[QW-1]};
        sub_b = UW'(count_q);
      end
    endcase
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = !diff[UW];

  always_comb begin
    state_d      = state_q;
    q_d          = q_q;
    rem_d        = rem_q;
    root_d       = root_q;
    count_d      = count_q;
    cnt_d        = cnt_q;
    res_d.done     = 1'b0;
    res_d.estimate = res_q.estimate;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          q_d     = QW'({prod, {(2 * FRACTION_BITS){1'b0}}});
          rem_d   = '0;
          count_d = count_i;
          cnt_d   = CW'(QW - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = ge ? diff[UW-1:0] : sub_a;
        q_d   = {q_q[QW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          // quotient now sits in q, ready as the radicand
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = CW'(RB - 1);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rem_d  = ge ? diff[UW-1:0] : sub_a;
        q_d    = {q_q[QW-3:0], 2'b00};
        root_d = {root_q[RB-2:0], ge};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        res_d.done     = 1'b1;
        res_d.estimate = (root_w > MW'(EST_MAX)) ? EST_MAX : root_w[EST_BITS-1:0];
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      q_q     <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      count_q <= '0;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      q_q     <= q_d;
      rem_q   <= rem_d;
      root_q  <= root_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/coprime_pair_pi_estimator.sv */
// Top level of the coprime-pair pi estimator
//
// Input channel: one 64-bit random sample per beat (sample_valid_i / sample_stall_o).
// The first sample after reset is only stored; every later sample is paired with
// the one before it and run through a binary gcd unit, one shift or subtract per cycle.
// The input stalls while a pair or an estimate is being worked on, and while a
// finished result waits to enter the output register.
// After sample_size pairs (APB register at byte address 0, reset 1000) a window
// with a nonzero coprime count computes its estimate on the estimate unit, in
// 36+2*FRACTION_BITS divide steps plus 18+FRACTION_BITS square-root steps, one
// bit per cycle on a shared subtractor.
// Output channel: coprime_count_o, pi_estimate_o (Q18.28), window_number_o per beat
// (result_valid_o / result_stall_i), held in an output register, so the next sample
// is taken while a result waits; only a further result waits for it to drain.
// Reset clears all counts, the stored sample and the output valid.
module coprime_pair_pi_estimator import cppe_pkg::*; #(
  parameter int unsigned SAMPLE_BITS   = 64,
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      sample_valid_i,
  output logic                      sample_stall_o,
  input  logic [SAMPLE_IN_BITS-1:0] sample_i,
  output logic                      result_valid_o,
  input  logic                      result_stall_i,
  output logic [CNT_BITS-1:0]       coprime_count_o,
  output logic [EST_BITS-1:0]       pi_estimate_o,
  output logic [CNT_BITS-1:0]       window_number_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_BITS-1:0]  paddr,
  input  logic [CFG_DATA_BITS-1:0]  pwdata,
  output logic [CFG_DATA_BITS-1:0]  prdata,
  output logic                      pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_GCD, ST_EST, ST_PUSH} state_e;

  state_e                 state_q, state_d;
  logic                   primed_q, primed_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [CNT_BITS-1:0]    size_q, size_d;
  logic [CNT_BITS-1:0]    pairs_q, pairs_d;
  logic [CNT_BITS-1:0]    tally_q, tally_d;
  logic [CNT_BITS-1:0]    windows_q, windows_d;
  logic                   est_start_q, est_start_d;
  logic                   out_valid_q, out_valid_d;
  logic [CNT_BITS-1:0]    out_count_q, out_count_d;
  logic [EST_BITS-1:0]    out_est_q, out_est_d;
  logic [CNT_BITS-1:0]    out_win_q, out_win_d;

  logic                   sample_acc, gcd_start, cfg_wr, reg_hit, out_free;
  logic [SAMPLE_BITS-1:0] sample_m;
  logic [CNT_BITS-1:0]    tally_new, pairs_next;
  gcd_res_t               gcd_res;
  est_res_t               est_res;

  assign sample_m   = sample_i[SAMPLE_BITS-1:0];
  assign sample_acc = sample_valid_i && (state_q == ST_IDLE);
  assign gcd_start  = sample_acc && primed_q;
  assign reg_hit    = (paddr[CFG_ADDR_BITS-1:2] == REG_SAMPLE_SIZE);
  assign cfg_wr     = psel && penable && pwrite && reg_hit;
  assign out_free   = !out_valid_q || !result_stall_i;
  assign tally_new  = tally_q + CNT_BITS'(gcd_res.coprime);
  assign pairs_next = pairs_q + 32'd1;

  cppe_gcd #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gcd_start),
    .a_i    (prev_q),
    .b_i    (sample_m),
    .res_o  (gcd_res)
  );

  cppe_est #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_est (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (est_start_q),
    .sample_size_i(size_q),
    .count_i      (tally_q),
    .res_o        (est_res)
  );

  always_comb begin
    state_d     = state_q;
    primed_d    = primed_q;
    prev_d      = prev_q;
    size_d      = cfg_wr ? pwdata : size_q;
    pairs_d     = pairs_q;
    tally_d     = tally_q;
    windows_d   = windows_q;
    est_start_d = 1'b0;
    out_valid_d = out_valid_q && result_stall_i;
    out_count_d = out_count_q;
    out_est_d   = out_est_q;
    out_win_d   = out_win_q;
    case (state_q)
      ST_IDLE: begin
        if (sample_acc) begin
          prev_d   = sample_m;
          primed_d = 1'b1;
          if (primed_q) begin
            state_d = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (gcd_res.done) begin
          tally_d = tally_new;
          if (pairs_next >= size_q) begin
            pairs_d = '0;
            // an empty window gives nothing and runs on
            if (tally_new != '0) begin
              est_start_d = 1'b1;
              state_d     = ST_EST;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            pairs_d = pairs_next;
            state_d = ST_IDLE;
          end
        end
      end
      ST_EST: begin
        if (est_res.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = tally_q;
          out_est_d   = est_res.estimate;
          out_win_d   = windows_q + 32'd1;
          windows_d   = windows_q + 32'd1;
          tally_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= 1'b0;
      prev_q      <= '0;
      size_q      <= SAMPLE_SIZE_RESET;
      pairs_q     <= '0;
      tally_q     <= '0;
      windows_q   <= '0;
      est_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
      out_est_q   <= '0;
      out_win_q   <= '0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      prev_q      <= prev_d;
      size_q      <= size_d;
      pairs_q     <= pairs_d;
      tally_q     <= tally_d;
      windows_q   <= windows_d;
      est_start_q <= est_start_d;
      out_valid_q <= out_valid_d;
      out_count_q <= out_count_d;
      out_est_q   <= out_est_d;
      out_win_q   <= out_win_d;
    end
  end

  assign sample_stall_o  = (state_q != ST_IDLE);
  assign result_valid_o  = out_valid_q;
  assign coprime_count_o = out_count_q;
  assign pi_estimate_o   = out_est_q;
  assign window_number_o = out_win_q;
  assign pready          = 1'b1;
  assign prdata          = reg_hit ? size_q : '0;

endmodule

/* rtl/cppe_checker.sv */
// Port-level checker for the pi estimator, bound to the top level
`include "coprime_pair_pi_estimator_assert.svh"

module cppe_checker import cppe_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                result_valid_o,
  input logic                result_stall_i,
  input logic [CNT_BITS-1:0] coprime_count_o,
  input logic [EST_BITS-1:0] pi_estimate_o,
  input logic [CNT_BITS-1:0] window_number_o
);

  logic                                 took, held, win_step;
  logic [CNT_BITS-1:0]                  win_last_q;
  logic [2*CNT_BITS+EST_BITS-1:0]       res_bus;

  assign took     = result_valid_o && !result_stall_i;
  assign held     = result_valid_o && result_stall_i;
  assign win_step = (window_number_o == win_last_q + 32'd1);
  assign res_bus  = {coprime_count_o, pi_estimate_o, window_number_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_last_q <= '0;
    end else begin
      win_last_q <= window_number_o;
    end
  end

  // a finished window always holds at least one coprime pair
  `CPPE_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni, result_valid_o, coprime_count_o != '0)

  // a result shown right after one was taken is the next window
  `CPPE_ASSERT_IMP(a_window_step, clk_i, rst_ni, took ##1 result_valid_o, win_step)

  `CPPE_ASSERT_NXT(a_result_hold, clk_i, rst_ni, held, result_valid_o && $stable(res_bus))

endmodule

bind coprime_pair_pi_estimator cppe_checker u_cppe_checker (.*);

/* test/coprime_pair_pi_estimator_checker.sv */
// Checker for the pi estimator: predicts window results from accepted samples and compares them
`timescale 1ns / 1ps

module pi_window_checker import cppe_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      sample_valid_i,
  input  logic                      sample_stall_i,
  input  logic [SAMPLE_IN_BITS-1:0] sample_i,
  input  logic                      result_valid_i,
  input  logic                      result_stall_i,
  input  logic [CNT_BITS-1:0]       coprime_count_i,
  input  logic [EST_BITS-1:0]       pi_estimate_i,
  input  logic [CNT_BITS-1:0]       window_number_i,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_BITS-1:0]  paddr,
  input  logic [CFG_DATA_BITS-1:0]  pwdata,
  input  logic                      pready,
  output int unsigned               mismatch_count_o,
  output int unsigned               windows_pending_o,
  output int unsigned               samples_seen_o,
  output int unsigned               windows_checked_o
);

  typedef struct {
    logic [CNT_BITS-1:0] count;
    logic [EST_BITS-1:0] estimate;
    logic [CNT_BITS-1:0] window;
  } window_result_t;

  window_result_t expected_windows[$];

  logic [CNT_BITS-1:0]       window_size;
  logic [SAMPLE_IN_BITS-1:0] last_sample;
  logic                      have_sample;
  logic [CNT_BITS-1:0]       pairs_counted;
  logic [CNT_BITS-1:0]       coprime_tally;
  logic [CNT_BITS-1:0]       windows_done;
  int unsigned               mismatches;
  int unsigned               samples_seen;
  int unsigned               windows_checked;

  assign mismatch_count_o  = mismatches;
  assign windows_pending_o = expected_windows.size();
  assign samples_seen_o    = samples_seen;
  assign windows_checked_o = windows_checked;

  function automatic logic [SAMPLE_IN_BITS-1:0] euclid_gcd(logic [SAMPLE_IN_BITS-1:0] a,
                                                           logic [SAMPLE_IN_BITS-1:0] b);
    logic [SAMPLE_IN_BITS-1:0] t;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // floor(sqrt(floor(6*size*2^(2F)/count))), saturated to the estimate width
  function automatic logic [EST_BITS-1:0] pi_fixed_estimate(logic [CNT_BITS-1:0] size,
                                                            logic [CNT_BITS-1:0] count);
    logic [127:0] scaled;
    logic [127:0] root;
    logic [127:0] trial;
    int           b;
    scaled = (128'(size) * 128'd6) << (2 * FRACTION_BITS);
    scaled = scaled / 128'(count);
    root   = '0;
    for (b = 63; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    if (root > 128'(EST_MAX)) return EST_MAX;
    return root[EST_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t exp_w;
    if (!rst_ni) begin
      expected_windows.delete();
      window_size     = SAMPLE_SIZE_RESET;
      last_sample     = '0;
      have_sample     = 1'b0;
      pairs_counted   = '0;
      coprime_tally   = '0;
      windows_done    = '0;
      mismatches      = 0;
      samples_seen    = 0;
      windows_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[CFG_ADDR_BITS-1:2] == REG_SAMPLE_SIZE) begin
        window_size = pwdata[CNT_BITS-1:0];
      end

      if (sample_valid_i && !sample_stall_i) begin
        samples_seen++;
        if (!have_sample) begin
          // first beat after reset only primes the pair
          last_sample = sample_i;
          have_sample = 1'b1;
        end else begin
          if (euclid_gcd(last_sample, sample_i) == 64'd1) coprime_tally++;
          last_sample = sample_i;
          pairs_counted++;
          if (pairs_counted >= window_size) begin
            pairs_counted = '0;
            // an empty window closes silently and the tally stays zero
            if (coprime_tally != '0) begin
              windows_done++;
              exp_w.count    = coprime_tally;
              exp_w.estimate = pi_fixed_estimate(window_size, coprime_tally);
              exp_w.window   = windows_done;
              expected_windows.push_back(exp_w);
              coprime_tally = '0;
            end
          end
        end
      end

      if (result_valid_i && !result_stall_i) begin
        if (expected_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result beat: count %0d est %h window %0d",
                     $realtime, coprime_count_i, pi_estimate_i, window_number_i);
        end else begin
          exp_w = expected_windows.pop_front();
          windows_checked++;
          if (exp_w.count != coprime_count_i || exp_w.estimate != pi_estimate_i ||
              exp_w.window != window_number_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] window mismatch: count exp %0d got %0d, est exp %h got %h, window exp %0d got %0d",
                       $realtime, exp_w.count, coprime_count_i, exp_w.estimate,
                       pi_estimate_i, exp_w.window, window_number_i);
          end
        end
      end
    end
  end

endmodule

/* test/tb_coprime_pair_pi_estimator.sv */
// Testbench top for the pi estimator: clock, reset, sample and register stimulus, verdict
`timescale 1ns / 1ps

module tb_coprime_pair_pi_estimator;
  import cppe_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 400;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      sample_valid;
  logic                      sample_stall;
  logic [SAMPLE_IN_BITS-1:0] sample;
  logic                      result_valid;
  logic                      result_stall;
  logic [CNT_BITS-1:0]       coprime_count;
  logic [EST_BITS-1:0]       pi_estimate;
  logic [CNT_BITS-1:0]       window_number;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_BITS-1:0]  paddr;
  logic [CFG_DATA_BITS-1:0]  pwdata;
  logic [CFG_DATA_BITS-1:0]  prdata;
  logic                      pready;

  int unsigned mismatch_count;
  int unsigned windows_pending;
  int unsigned samples_seen;
  int unsigned windows_checked;

  // no random idling on either side while set
  logic steady;
  int   hold_asks;

  coprime_pair_pi_estimator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_valid_i  (sample_valid),
    .sample_stall_o  (sample_stall),
    .sample_i        (sample),
    .result_valid_o  (result_valid),
    .result_stall_i  (result_stall),
    .coprime_count_o (coprime_count),
    .pi_estimate_o   (pi_estimate),
    .window_number_o (window_number),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  pi_window_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_valid_i    (sample_valid),
    .sample_stall_i    (sample_stall),
    .sample_i          (sample),
    .result_valid_i    (result_valid),
    .result_stall_i    (result_stall),
    .coprime_count_i   (coprime_count),
    .pi_estimate_i     (pi_estimate),
    .window_number_i   (window_number),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .mismatch_count_o  (mismatch_count),
    .windows_pending_o (windows_pending),
    .samples_seen_o    (samples_seen),
    .windows_checked_o (windows_checked)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int served;
    int hold_left;
    served       = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != served) begin
        served = hold_asks;
        for (hold_left = 600; hold_left > 0; hold_left--) begin
          result_stall <= 1'b1;
          @(negedge clk_i);
        end
      end
      result_stall <= !steady && ($urandom_range(0, 99) < 24);
    end
  end

  task automatic send_sample(input logic [SAMPLE_IN_BITS-1:0] value);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 24) begin
      sample_valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    @(posedge clk_i);
    while (sample_stall) @(posedge clk_i);
  endtask

  // stop offering, let every expected window arrive, then cover a pair still in the gcd
  task automatic settle_block();
    @(negedge clk_i);
    sample_valid <= 1'b0;
    while (windows_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sample_size(input logic [CNT_BITS-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SAMPLE_SIZE, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [SAMPLE_IN_BITS-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return {$urandom, $urandom};
    if (pick < 70) return 64'($urandom_range(0, 255));
    // shared low zero bits make non-coprime pairs common
    if (pick < 85) return {$urandom, $urandom} << $urandom_range(1, 40);
    if (pick < 95) return 64'($urandom_range(1, 2000)) * 64'(6 * $urandom_range(1, 50));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 64'd1;
      2:       return '1;
      default: return 64'h8000_0000_0000_0000;
    endcase
  endfunction

  task automatic run_random_phase(input logic [CNT_BITS-1:0] size, input int count);
    int n;
    write_sample_size(size);
    for (n = 0; n < count; n++) send_sample(random_sample());
    settle_block();
  endtask

  initial begin
    rst_ni       = 1'b0;
    sample_valid = 1'b0;
    sample       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady       = 1'b0;
    hold_asks    = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // every pair closes a window
    write_sample_size(32'd1);
    send_sample(64'd0);                      // primes only
    send_sample(64'd0);                      // gcd(0,0) = 0, empty window
    send_sample(64'd1);                      // gcd(0,1) = 1
    send_sample('1);
    send_sample(64'hFFFF_FFFF_FFFF_FFFE);
    send_sample(64'h8000_0000_0000_0000);
    send_sample(64'h4000_0000_0000_0000);
    send_sample(64'd3);
    send_sample(64'd0);
    send_sample(64'd7540113804746346429);    // consecutive Fibonacci numbers
    send_sample(64'd12200160415121876738);
    settle_block();

    // zero window size: each pair closes a window, estimate is zero
    write_sample_size(32'd0);
    send_sample(64'd35);
    send_sample(64'd49);
    send_sample(64'd50);
    send_sample(64'd0);
    settle_block();

    // huge window, then lowered below the pairs already counted
    write_sample_size(32'hFFFF_FFFF);
    send_sample(64'd5);
    send_sample(64'd7);
    send_sample(64'd11);
    send_sample(64'd13);
    settle_block();
    write_sample_size(32'd2);
    send_sample(64'd17);
    settle_block();

    // long result hold-off while samples keep coming
    hold_asks++;
    run_random_phase(32'd1, 250);
    steady = 1'b1;
    run_random_phase(32'd3, 400);
    steady = 1'b0;
    run_random_phase(32'($urandom_range(4, 12)), 500);
    run_random_phase(32'd200, 400);
    run_random_phase(32'($urandom_range(1, 30)), 400);

    $display("covered %0d samples and %0d checked window estimates", samples_seen,
             windows_checked);
    $display("window sizes 0, 1, 2, 3, 200, random, and 2^32-1 lowered mid-window");
    if (mismatch_count == 0 && windows_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
